FILE: src/pf_pkg.sv
package pf_pkg;

  // square geometry
  localparam int SIDE        = 5;
  localparam int CELLS       = SIDE * SIDE;
  localparam int NUM_LETTERS = 26;

  // letter codes, A is zero
  localparam logic [4:0] CODE_I = 5'd8;
  localparam logic [4:0] CODE_J = 5'd9;
  localparam logic [4:0] CODE_X = 5'd23;
  localparam logic [4:0] CODE_Z = 5'd25;

  // ascii bounds for key bytes
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5a;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // op field of an input beat
  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_FINISH  = 2'd1,
    OP_ENCRYPT = 2'd2
  } pf_op_t;

  // command kinds in the queue
  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_FINISH,
    CMD_ENCRYPT
  } pf_kind_t;

  typedef struct packed {
    pf_kind_t   kind;
    logic [4:0] key_code;
    logic [4:0] first;
    logic [4:0] second;
  } pf_cmd_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_OUT
  } pf_state_t;

  // clamp to Z and fold J onto I
  function automatic logic [4:0] pf_clean(input logic [4:0] code);
    logic [4:0] c;
    c = (code > CODE_Z) ? CODE_Z : code;
    if (c == CODE_J) c = CODE_I;
    return c;
  endfunction

  // row of a square index
  function automatic logic [2:0] pf_row(input logic [4:0] pos);
    logic [4:0] p;
    logic [2:0] r;
    p = (pos >= 5'(CELLS)) ? pos - 5'(CELLS) : pos;
    r = 3'd0;
    for (int i = 1; i < SIDE; i++) begin
      if (p >= 5'(i * SIDE)) r = 3'(i);
    end
    return r;
  endfunction

  // column of a square index
  function automatic logic [2:0] pf_col(input logic [4:0] pos);
    logic [4:0] p;
    p = (pos >= 5'(CELLS)) ? pos - 5'(CELLS) : pos;
    return 3'(p - 5'(pf_row(pos)) * 5'(SIDE));
  endfunction

  // wrap to the next row or column
  function automatic logic [2:0] pf_next(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] pf_addr(input logic [2:0] row, input logic [2:0] col);
    return 5'(row) * 5'(SIDE) + 5'(col);
  endfunction

endpackage

FILE: src/pf_in_if.sv
interface pf_in_if;
  import pf_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key_byte;
  logic [4:0] first_letter;
  logic [4:0] second_letter;
  logic       second_present;

  modport source (
    output valid, op, key_byte, first_letter, second_letter, second_present,
    input  ready
  );

  modport sink (
    input  valid, op, key_byte, first_letter, second_letter, second_present,
    output ready
  );
endinterface

FILE: src/pf_out_if.sv
interface pf_out_if;
  import pf_pkg::*;

  logic       valid;
  logic       ready;
  logic [4:0] cipher_first;
  logic [4:0] cipher_second;
  logic       not_ready;

  modport source (
    output valid, cipher_first, cipher_second, not_ready,
    input  ready
  );

  modport sink (
    input  valid, cipher_first, cipher_second, not_ready,
    output ready
  );
endinterface

FILE: src/playfair_cipher_encrypt.sv
// channel  | dir | payload                                           | beat on
// in_ch    | in  | op, key_byte, first_letter, second_letter, s._pres | valid & ready
// out_ch   | out | cipher_first, cipher_second, not_ready            | valid & ready
//
// key byte: placed by the back end while idle; finish: a sweep over the alphabet, J skipped
// encrypt: the position read then the square read (both registered), then the output register
// front takes beats while the command queue has room, also during a stalled result
// synchronous active-low reset clears the square state; no clearing pass
module playfair_cipher_encrypt
  import pf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  pf_in_if.sink     in_ch,
  pf_out_if.source  out_ch
);

  logic    push_valid, push_ready;
  pf_cmd_t push_data;
  logic    pop_valid, pop_ready;
  pf_cmd_t pop_data;

  pf_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .deq_valid (pop_valid),
    .deq_ready (pop_ready),
    .deq_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: src/pf_front.sv
module pf_front
  import pf_pkg::*;
(
  pf_in_if.sink   in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output pf_cmd_t push_data
);

  logic [7:0] upper;
  logic       is_letter;
  logic [4:0] key_code;
  logic [4:0] first_c;
  logic [4:0] second_c;
  logic       keep;

  // key byte to letter code
  always_comb begin
    upper = in_ch.key_byte;
    if (in_ch.key_byte >= CHAR_LA && in_ch.key_byte <= CHAR_LZ) begin
      upper = in_ch.key_byte - CASE_OFFSET;
    end
    is_letter = (upper >= CHAR_UA) && (upper <= CHAR_UZ);
    key_code  = 5'(upper - CHAR_UA);
    if (key_code == CODE_J) key_code = CODE_I;
  end

  // digraph cleanup: padding and doubled letters
  always_comb begin
    first_c  = pf_clean(in_ch.first_letter);
    second_c = in_ch.second_present ? pf_clean(in_ch.second_letter) : CODE_X;
    if (first_c == second_c) second_c = CODE_X;
  end

  // classify the beat, drop non-letter key bytes and unused ops
  always_comb begin
    keep           = 1'b0;
    push_data.kind = CMD_KEY;
    unique case (in_ch.op)
      OP_KEY: begin
        keep           = is_letter;
        push_data.kind = CMD_KEY;
      end
      OP_FINISH: begin
        keep           = 1'b1;
        push_data.kind = CMD_FINISH;
      end
      OP_ENCRYPT: begin
        keep           = 1'b1;
        push_data.kind = CMD_ENCRYPT;
      end
      default: keep = 1'b0;
    endcase
    push_data.key_code = key_code;
    push_data.first    = first_c;
    push_data.second   = second_c;
  end

  assign push_valid  = in_ch.valid && keep;
  assign in_ch.ready = push_ready;

endmodule

FILE: src/pf_queue.sv
module pf_queue
  import pf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  pf_cmd_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output pf_cmd_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pf_cmd_t         slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: src/pf_back.sv
module pf_back
  import pf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      deq_valid,
  output logic      deq_ready,
  input  pf_cmd_t   deq_data,
  pf_out_if.source  out_ch
);

  pf_state_t               state_r, state_nxt;
  logic [NUM_LETTERS-1:0]  used_r;
  logic [4:0]              fill_r;
  logic                    ready_r, ready_nxt;
  logic [4:0]              sweep_r, sweep_nxt;
  logic                    err_r, err_nxt;

  logic [4:0]              square_mem [CELLS];
  logic [4:0]              pos_mem [NUM_LETTERS];
  logic [4:0]              pos1_r, pos2_r;
  logic [4:0]              sq1_r, sq2_r;

  logic                    out_valid_r;
  logic [4:0]              out_first_r, out_second_r;
  logic                    out_err_r;

  logic                    place_en, place_ok;
  logic [4:0]              place_code;
  logic                    load_out, out_free;

  logic [2:0]              r1, c1, r2, c2;
  logic [4:0]              addr1, addr2;

  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    sweep_nxt  = sweep_r;
    ready_nxt  = ready_r;
    err_nxt    = err_r;
    deq_ready  = 1'b0;
    place_en   = 1'b0;
    place_code = deq_data.key_code;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        deq_ready = 1'b1;
        if (deq_valid) begin
          unique case (deq_data.kind)
            CMD_KEY: place_en = !ready_r;
            CMD_FINISH: begin
              if (!ready_r) begin
                state_nxt = ST_FILL;
                sweep_nxt = '0;
              end
            end
            CMD_ENCRYPT: begin
              err_nxt   = !ready_r;
              state_nxt = ready_r ? ST_POS : ST_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_en   = (sweep_r != CODE_J);
        place_code = sweep_r;
        sweep_nxt  = sweep_r + 5'd1;
        if (sweep_r == CODE_Z) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_POS: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign place_ok = place_en && !used_r[place_code] && (fill_r < 5'(CELLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      fill_r  <= '0;
      ready_r <= 1'b0;
      sweep_r <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      sweep_r <= sweep_nxt;
      err_r   <= err_nxt;
      if (place_ok) begin
        used_r[place_code] <= 1'b1;
        fill_r             <= fill_r + 5'd1;
      end
    end
  end

  // square and position memories
  always_ff @(posedge clk) begin
    if (place_ok) begin
      square_mem[fill_r]  <= place_code;
      pos_mem[place_code] <= fill_r;
    end
    if (state_r == ST_IDLE) begin
      pos1_r <= pos_mem[deq_data.first];
      pos2_r <= pos_mem[deq_data.second];
    end
    if (state_r == ST_POS) begin
      sq1_r <= square_mem[addr1];
      sq2_r <= square_mem[addr2];
    end
  end

  // playfair rules on row and column
  always_comb begin
    r1 = pf_row(pos1_r);
    c1 = pf_col(pos1_r);
    r2 = pf_row(pos2_r);
    c2 = pf_col(pos2_r);
    if (r1 == r2) begin
      addr1 = pf_addr(r1, pf_next(c1));
      addr2 = pf_addr(r2, pf_next(c2));
    end else if (c1 == c2) begin
      addr1 = pf_addr(pf_next(r1), c1);
      addr2 = pf_addr(pf_next(r2), c2);
    end else begin
      addr1 = pf_addr(r1, c2);
      addr2 = pf_addr(r2, c1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_first_r  <= err_r ? '0 : sq1_r;
      out_second_r <= err_r ? '0 : sq2_r;
      out_err_r    <= err_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cipher_first  = out_first_r;
  assign out_ch.cipher_second = out_second_r;
  assign out_ch.not_ready     = out_err_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 5'(CELLS))
    else $error("fill count past square size");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (fill_r == 5'(CELLS)))
    else $error("square marked ready but not full");

  a_lookup_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POS) |-> ready_r)
    else $error("lookup started on unfinished square");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside output state");

endmodule

FILE: verif/playfair_cipher_encrypt_test.sv
module playfair_cipher_encrypt_test;
  import pf_pkg::*;

  // op code that the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // highest code the 5-bit letter fields can carry
  localparam logic [4:0] CODE_TOP = 5'd31;
  localparam int RANDOM_ENCRYPTS = 600;

  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       early;
  } cipher_t;

  logic clk = 1'b0;
  logic rst_n;

  pf_in_if  in_ch ();
  pf_out_if out_ch ();

  playfair_cipher_encrypt i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // key square as the block should hold it
  logic [4:0] sq_cell [CELLS];
  logic [4:0] letter_cell [NUM_LETTERS];
  bit         letter_taken [NUM_LETTERS];
  int         cells_filled;
  bit         square_done;

  cipher_t pending_ciphers [$];
  int      mismatches;
  int      beats_sent;
  bit      no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [4:0] fold_code(logic [4:0] code);
    logic [4:0] c;
    c = (code > CODE_Z) ? CODE_Z : code;
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  function automatic void place_in_square(logic [4:0] code);
    if (code > CODE_Z || letter_taken[code] || cells_filled >= CELLS) return;
    letter_taken[code] = 1'b1;
    sq_cell[cells_filled] = code;
    letter_cell[code] = 5'(cells_filled);
    cells_filled++;
  endfunction

  // update the square and queue the cipher pair one beat should produce
  function automatic void predict_cipher(logic [1:0] op, logic [7:0] kb, logic [4:0] l1,
                                         logic [4:0] l2, logic sp);
    cipher_t due;
    logic [7:0] ch;
    logic [4:0] a, b;
    int r1, c1, r2, c2;
    case (op)
      OP_KEY: begin
        if (!square_done) begin
          ch = (kb >= CHAR_LA && kb <= CHAR_LZ) ? kb - CASE_OFFSET : kb;
          if (ch >= CHAR_UA && ch <= CHAR_UZ) place_in_square(fold_code(5'(ch - CHAR_UA)));
        end
      end
      OP_FINISH: begin
        if (!square_done) begin
          for (int c = 0; c < NUM_LETTERS; c++) begin
            if (5'(c) != CODE_J) place_in_square(5'(c));
          end
          square_done = 1'b1;
        end
      end
      OP_ENCRYPT: begin
        if (!square_done) begin
          due = '{first: 5'd0, second: 5'd0, early: 1'b1};
        end else begin
          a = fold_code(l1);
          b = sp ? fold_code(l2) : CODE_X;
          if (a == b) b = CODE_X;
          r1 = letter_cell[a] / SIDE;
          c1 = letter_cell[a] % SIDE;
          r2 = letter_cell[b] / SIDE;
          c2 = letter_cell[b] % SIDE;
          due.early = 1'b0;
          if (r1 == r2) begin
            due.first  = sq_cell[r1 * SIDE + (c1 + 1) % SIDE];
            due.second = sq_cell[r2 * SIDE + (c2 + 1) % SIDE];
          end else if (c1 == c2) begin
            due.first  = sq_cell[((r1 + 1) % SIDE) * SIDE + c1];
            due.second = sq_cell[((r2 + 1) % SIDE) * SIDE + c2];
          end else begin
            due.first  = sq_cell[r1 * SIDE + c2];
            due.second = sq_cell[r2 * SIDE + c1];
          end
        end
        pending_ciphers.push_back(due);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // one beat on the input channel, with a random gap ahead of it
  task automatic send_beat(logic [1:0] op, logic [7:0] kb, logic [4:0] l1, logic [4:0] l2,
                           logic sp);
    int gap;
    if (beats_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.key_byte       <= kb;
    in_ch.first_letter   <= l1;
    in_ch.second_letter  <= l2;
    in_ch.second_present <= sp;
    do @(posedge clk); while (!in_ch.ready);
    predict_cipher(op, kb, l1, l2, sp);
    beats_sent++;
  endtask

  // hold the input idle until every queued cipher pair is out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_ciphers.size() != 0);
  endtask

  function automatic logic [4:0] draw_letter();
    return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 25));
  endfunction

  // result side: random stalls, compare each beat with the oldest pair
  initial begin : result_sink
    int stall;
    cipher_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_ciphers.size() == 0) begin
        note_mismatch("result with nothing pending", 0, out_ch.cipher_first);
      end else begin
        want = pending_ciphers.pop_front();
        if (out_ch.cipher_first !== want.first)
          note_mismatch("cipher_first", want.first, out_ch.cipher_first);
        if (out_ch.cipher_second !== want.second)
          note_mismatch("cipher_second", want.second, out_ch.cipher_second);
        if (out_ch.not_ready !== want.early)
          note_mismatch("not_ready", want.early, out_ch.not_ready);
      end
    end
  end

  // key bytes: case folding, J as I, non-letters and repeats
  task automatic test_key_entry();
    send_beat(OP_KEY, "p", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "L", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "j", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "I", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "J", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "l", 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, 8'h00, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, 8'hff, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, CHAR_UA - 8'd1, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, CHAR_UZ + 8'd1, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, CHAR_LA - 8'd1, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, CHAR_LZ + 8'd1, 5'd0, 5'd0, 1'b0);
    send_beat(OP_KEY, "z", 5'd0, 5'd0, 1'b0);
  endtask

  // encrypt and unused op before the square is complete
  task automatic test_early_encrypt();
    send_beat(OP_ENCRYPT, 8'h00, 5'd0, CODE_Z, 1'b1);
    send_beat(OP_ENCRYPT, 8'hff, CODE_TOP, CODE_TOP, 1'b0);
    send_beat(OP_UNUSED, "a", 5'd3, 5'd4, 1'b1);
  endtask

  // rest of the key at random, mostly letters, some early encrypts
  task automatic test_random_key();
    int count;
    logic [7:0] kb;
    count = $urandom_range(4, 40);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0: send_beat(OP_ENCRYPT, 8'($urandom), draw_letter(), draw_letter(), 1'($urandom));
        1: send_beat(OP_UNUSED, 8'($urandom), draw_letter(), draw_letter(), 1'($urandom));
        2, 3: send_beat(OP_KEY, 8'($urandom), draw_letter(), draw_letter(), 1'($urandom));
        default: begin
          kb = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA);
          send_beat(OP_KEY, kb, draw_letter(), draw_letter(), 1'($urandom));
        end
      endcase
    end
  endtask

  // finish, a second finish and a late key byte are both dropped
  task automatic test_finish();
    send_beat(OP_FINISH, 8'h00, 5'd0, 5'd0, 1'b0);
    send_beat(OP_FINISH, 8'hff, CODE_TOP, CODE_TOP, 1'b1);
    send_beat(OP_KEY, "q", 5'd0, 5'd0, 1'b0);
  endtask

  // row, column and rectangle rules plus the padding cases
  task automatic test_rule_cases();
    logic [4:0] l;
    l = 5'($urandom_range(0, 25));
    send_beat(OP_ENCRYPT, 8'h00, sq_cell[0], sq_cell[1], 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, sq_cell[4], sq_cell[3], 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, sq_cell[0], sq_cell[5], 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, sq_cell[20], sq_cell[15], 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, sq_cell[6], sq_cell[18], 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, l, l, 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, CODE_X, CODE_X, 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, l, CODE_TOP, 1'b0);
    send_beat(OP_ENCRYPT, 8'h00, CODE_J, CODE_I, 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, CODE_TOP, CODE_Z + 5'd1, 1'b1);
    send_beat(OP_ENCRYPT, 8'h00, 5'd0, CODE_Z, 1'b1);
  endtask

  // bulk encrypts with some dropped beats, one full drain midway
  task automatic test_random_traffic();
    int encrypts;
    logic [4:0] a;
    encrypts = 0;
    while (encrypts < RANDOM_ENCRYPTS) begin
      if (encrypts == RANDOM_ENCRYPTS / 2) wait_drained();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: send_beat(OP_KEY, 8'($urandom), draw_letter(), draw_letter(), 1'($urandom));
          1: send_beat(OP_FINISH, 8'($urandom), draw_letter(), draw_letter(), 1'($urandom));
          default: send_beat(OP_UNUSED, 8'($urandom), draw_letter(), draw_letter(),
                             1'($urandom));
        endcase
      end else begin
        a = draw_letter();
        send_beat(OP_ENCRYPT, 8'($urandom), a,
                  ($urandom_range(0, 5) == 0) ? a : draw_letter(),
                  ($urandom_range(0, 5) != 0));
        encrypts++;
      end
    end
  endtask

  initial begin : main_sequence
    int guard;
    mismatches   = 0;
    beats_sent   = 0;
    no_idle      = 1'b0;
    cells_filled = 0;
    square_done  = 1'b0;
    foreach (letter_taken[i]) letter_taken[i] = 1'b0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= OP_KEY;
    in_ch.key_byte       <= 8'h00;
    in_ch.first_letter   <= 5'd0;
    in_ch.second_letter  <= 5'd0;
    in_ch.second_present <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_key_entry();
    test_early_encrypt();
    test_random_key();
    test_finish();
    test_rule_cases();
    test_random_traffic();

    // drain, then give the back end time to settle
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_ciphers.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (pending_ciphers.size() != 0)
      note_mismatch("results never delivered", pending_ciphers.size(), 0);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
